// ===== rtl/pts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// shared types and codes of the periodic timer scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] KIND_FIRED   = 3'd0;
  localparam logic [2:0] KIND_ADDED   = 3'd1;
  localparam logic [2:0] KIND_REMOVED = 3'd2;
  localparam logic [2:0] KIND_UNKNOWN = 3'd3;
  localparam logic [2:0] KIND_FULL    = 3'd4;

  localparam logic [31:0] COUNT_FOREVER = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_LOAD,
    CELL_FIRE,
    CELL_FREE
  } cell_op_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_t    op;
    logic [31:0] id;
    logic [63:0] deadline;
    logic [31:0] period;
    logic [31:0] remaining;
    logic        async_f;
    logic [31:0] order;
  } cell_ctrl_t;

  // best due timer seen so far, handed along the chain
  typedef struct packed {
    logic        found;
    logic [63:0] deadline;
    logic [31:0] age;
    logic [31:0] id;
    logic        async_f;
    logic        reload;
  } cand_t;

endpackage
`default_nettype wire

// ===== rtl/periodic_timer_scheduler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_timer_scheduler_core
// bank of periodic timers with add, remove and tick commands
// ----------------------------------------------------------------------------
// usage:
//  - input channel (in_valid / in_stall) carries one command transaction:
//    tick, add timer or remove timer
//  - output channel (out_valid / out_stall) returns result transactions;
//    out_last marks the final result of a command
//  - cfg channel (cfg_valid / cfg_ready) writes time_step; always ready
//  - add and remove answer with one result
//  - a tick runs one search wave through the row of TIMER_SLOTS cells per
//    fire, plus one wave to find that nothing more is due, at most
//    MAX_FIRES_PER_TICK fires; no final wave once that cap is reached
//  - each fire is held in a pending register so out_last can be set on the final one
//  - a stalled receiver holds the result register; a held fire waits for it
//  - reset (rst_n low, synchronous) frees all slots, clears time, ids and
//    stamps, and sets time_step to 1000
// ----------------------------------------------------------------------------
module periodic_timer_scheduler_core #(
  parameter int TIMER_SLOTS        = 16,
  parameter int MAX_FIRES_PER_TICK = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [31:0] in_interval,
  input  wire logic [31:0] in_loop_count,
  input  wire logic        in_async_flag,
  input  wire logic [31:0] in_timer_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [31:0]      out_result_id,
  output logic             out_result_async,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [19:0] cfg_data
);
  import pts_pkg::*;

  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int FW = $clog2(MAX_FIRES_PER_TICK + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [63:0]   now_r, now_nxt;
  logic [31:0]   next_id_r, next_id_nxt;
  logic [31:0]   order_r, order_nxt;
  logic [19:0]   step_r;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic [FW-1:0] fires_r, fires_nxt;
  logic [FW-1:0] fires_inc;
  logic          pend_r, pend_nxt;
  logic [31:0]   pend_id_r, pend_id_nxt;
  logic          pend_async_r, pend_async_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_kind_r, out_kind_nxt;
  logic [31:0]   out_id_r, out_id_nxt;
  logic          out_async_r, out_async_nxt;
  logic          out_last_r, out_last_nxt;

  cell_ctrl_t    ctrl;
  logic [SW-1:0] ctrl_slot;

  cand_t         cand [TIMER_SLOTS];
  logic [SW-1:0] cand_slot [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] valid_vec;
  logic [TIMER_SLOTS-1:0] match_vec;

  logic          in_acc;
  logic          out_free;
  logic          full;
  logic [SW-1:0] free_slot;
  logic          found_id;
  logic [SW-1:0] match_slot;
  logic [31:0]   interval_eff;
  cand_t         best;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_result_id    = out_id_r;
  assign out_result_async = out_async_r;
  assign out_last         = out_last_r;

  assign full         = &valid_vec;
  assign interval_eff = (in_interval == 32'd0) ? 32'd1 : in_interval;
  assign best         = cand[TIMER_SLOTS-1];
  assign fires_inc    = fires_r + FW'(1);

  // lowest free slot and lowest slot that carries the requested id
  always_comb begin
    free_slot  = '0;
    match_slot = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_vec[i]) free_slot = SW'(i);
      if (match_vec[i])  match_slot = SW'(i);
    end
  end
  assign found_id = |match_vec;

  // row of timer cells; the search wave enters at cell 0 with nothing found
  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
    cand_t         c_in;
    logic [SW-1:0] s_in;
    if (g == 0) begin : g_head
      assign c_in = '0;
      assign s_in = '0;
    end else begin : g_link
      assign c_in = cand[g-1];
      assign s_in = cand_slot[g-1];
    end
    pts_cell #(
      .SW  (SW),
      .IDX (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .ctrl_slot    (ctrl_slot),
      .now          (now_r),
      .order_now    (order_r),
      .rm_id        (in_timer_id),
      .cand_in      (c_in),
      .cand_slot_in (s_in),
      .cand_r       (cand[g]),
      .cand_slot_r  (cand_slot[g]),
      .valid_o      (valid_vec[g]),
      .match_o      (match_vec[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    now_nxt        = now_r;
    next_id_nxt    = next_id_r;
    order_nxt      = order_r;
    cnt_nxt        = cnt_r;
    fires_nxt      = fires_r;
    pend_nxt       = pend_r;
    pend_id_nxt    = pend_id_r;
    pend_async_nxt = pend_async_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_async_nxt = out_async_r;
    out_last_nxt  = out_last_r;

    ctrl           = '0;
    ctrl.op        = CELL_NOP;
    ctrl.id        = next_id_r + 32'd1;
    ctrl.deadline  = now_r + {32'd0, interval_eff};
    ctrl.period    = interval_eff;
    ctrl.remaining = in_loop_count - 32'd1;
    ctrl.async_f   = in_async_flag;
    ctrl.order     = order_r;
    ctrl_slot      = free_slot;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_TICK: begin
              now_nxt   = now_r + {44'd0, step_r};
              cnt_nxt   = '0;
              fires_nxt = '0;
              state_nxt = ST_SCAN;
            end
            CMD_ADD: begin
              out_valid_nxt = 1'b1;
              out_async_nxt = 1'b0;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_kind_nxt = KIND_FULL;
                out_id_nxt   = 32'd0;
              end else begin
                ctrl.op      = CELL_LOAD;
                next_id_nxt  = next_id_r + 32'd1;
                order_nxt    = order_r + 32'd1;
                out_kind_nxt = KIND_ADDED;
                out_id_nxt   = next_id_r + 32'd1;
              end
            end
            CMD_REMOVE: begin
              out_valid_nxt = 1'b1;
              out_async_nxt = 1'b0;
              out_last_nxt  = 1'b1;
              out_id_nxt    = in_timer_id;
              if (found_id) begin
                ctrl.op      = CELL_FREE;
                ctrl_slot    = match_slot;
                out_kind_nxt = KIND_REMOVED;
              end else begin
                out_kind_nxt = KIND_UNKNOWN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // wait while the wave passes through the row of cell registers
        cnt_nxt = cnt_r + SW'(1);
        if (cnt_r == SW'(TIMER_SLOTS - 1)) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (!best.found) begin
          state_nxt = ST_DONE;
        end else if (!pend_r || out_free) begin
          if (pend_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_FIRED;
            out_id_nxt    = pend_id_r;
            out_async_nxt = pend_async_r;
            out_last_nxt  = 1'b0;
          end
          pend_nxt       = 1'b1;
          pend_id_nxt    = best.id;
          pend_async_nxt = best.async_f;
          ctrl.op        = CELL_FIRE;
          ctrl_slot      = cand_slot[TIMER_SLOTS-1];
          if (best.reload) order_nxt = order_r + 32'd1;
          fires_nxt = fires_inc;
          cnt_nxt   = '0;
          state_nxt = (fires_inc == FW'(MAX_FIRES_PER_TICK)) ? ST_DONE : ST_SCAN;
        end
      end
      ST_DONE: begin
        if (!pend_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRED;
          out_id_nxt    = pend_id_r;
          out_async_nxt = pend_async_r;
          out_last_nxt  = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      next_id_r   <= '0;
      order_r     <= '0;
      step_r      <= 20'd1000;
      cnt_r       <= '0;
      fires_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      next_id_r   <= next_id_nxt;
      order_r     <= order_nxt;
      cnt_r       <= cnt_nxt;
      fires_r     <= fires_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) step_r <= cfg_data;
    end
    pend_id_r    <= pend_id_nxt;
    pend_async_r <= pend_async_nxt;
    out_kind_r   <= out_kind_nxt;
    out_id_r     <= out_id_nxt;
    out_async_r  <= out_async_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef ASSERT_OFF
  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fires_r <= FW'(MAX_FIRES_PER_TICK))
    else $error("fire count beyond cap");
  a_pend_only_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_r)
    else $error("held fire left behind after tick");
  a_add_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_cmd == CMD_ADD && !full) |=> valid_vec[$past(free_slot)])
    else $error("added timer slot not valid");
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r <= KIND_FULL))
    else $error("result kind out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/pts_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_cell
// one timer slot plus one stage of the earliest-due search chain
// ----------------------------------------------------------------------------
module pts_cell #(
  parameter int SW  = 4,
  parameter int IDX = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pts_pkg::cell_ctrl_t ctrl,
  input  wire logic [SW-1:0]       ctrl_slot,
  input  wire logic [63:0]         now,
  input  wire logic [31:0]         order_now,
  input  wire logic [31:0]         rm_id,
  input  wire pts_pkg::cand_t      cand_in,
  input  wire logic [SW-1:0]       cand_slot_in,
  output pts_pkg::cand_t           cand_r,
  output logic [SW-1:0]            cand_slot_r,
  output logic                     valid_o,
  output logic                     match_o
);
  import pts_pkg::*;

  logic        valid_r, valid_nxt;
  logic [31:0] id_r, id_nxt;
  logic [63:0] deadline_r, deadline_nxt;
  logic [31:0] period_r, period_nxt;
  logic [31:0] remaining_r, remaining_nxt;
  logic        async_r, async_nxt;
  logic [31:0] order_r, order_nxt;
  logic        hit;
  logic        due;
  logic [31:0] age;
  logic        take_self;
  cand_t       cand_nxt;
  logic [SW-1:0] cand_slot_nxt;

  assign hit     = (ctrl_slot == SW'(IDX));
  assign due     = valid_r && (deadline_r <= now);
  assign age     = order_now - order_r;
  assign valid_o = valid_r;
  assign match_o = valid_r && (id_r == rm_id);

  // earlier deadline wins, then the older stamp; lower slot wins a full tie
  assign take_self = due && (!cand_in.found || (deadline_r < cand_in.deadline) ||
                     ((deadline_r == cand_in.deadline) && (age > cand_in.age)));

  always_comb begin
    cand_nxt      = cand_in;
    cand_slot_nxt = cand_slot_in;
    if (take_self) begin
      cand_nxt.found    = 1'b1;
      cand_nxt.deadline = deadline_r;
      cand_nxt.age      = age;
      cand_nxt.id       = id_r;
      cand_nxt.async_f  = async_r;
      cand_nxt.reload   = (remaining_r != 32'd0);
      cand_slot_nxt     = SW'(IDX);
    end
  end

  always_comb begin
    valid_nxt     = valid_r;
    id_nxt        = id_r;
    deadline_nxt  = deadline_r;
    period_nxt    = period_r;
    remaining_nxt = remaining_r;
    async_nxt     = async_r;
    order_nxt     = order_r;
    if (hit) begin
      case (ctrl.op)
        CELL_LOAD: begin
          valid_nxt     = 1'b1;
          id_nxt        = ctrl.id;
          deadline_nxt  = ctrl.deadline;
          period_nxt    = ctrl.period;
          remaining_nxt = ctrl.remaining;
          async_nxt     = ctrl.async_f;
          order_nxt     = ctrl.order;
        end
        CELL_FIRE: begin
          if (remaining_r != 32'd0) begin
            if (remaining_r != COUNT_FOREVER) remaining_nxt = remaining_r - 32'd1;
            deadline_nxt = deadline_r + {32'd0, period_r};
            order_nxt    = ctrl.order;
          end else begin
            valid_nxt = 1'b0;
          end
        end
        CELL_FREE: valid_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    id_r        <= id_nxt;
    deadline_r  <= deadline_nxt;
    period_r    <= period_nxt;
    remaining_r <= remaining_nxt;
    async_r     <= async_nxt;
    order_r     <= order_nxt;
    cand_r      <= cand_nxt;
    cand_slot_r <= cand_slot_nxt;
  end

`ifndef ASSERT_OFF
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (hit && ctrl.op == CELL_LOAD) |=> valid_r)
    else $error("loaded slot not valid");
  a_free_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (hit && ctrl.op == CELL_FREE) |=> !valid_r)
    else $error("freed slot still valid");
  a_self_pick_due: assert property (@(posedge clk) disable iff (!rst_n)
    take_self |-> valid_r)
    else $error("empty slot offered as due");
`endif

endmodule
`default_nettype wire
